### hw/rtl/ths_pkg.sv
`default_nettype none
// ============================================================================
// ths_pkg
// Shared types and constants of the terrain height sampler.
// ============================================================================
package ths_pkg;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;
  localparam int POS_W       = 32;
  localparam int COORD_W     = 6;
  localparam int SAMPLE_W    = 24;
  localparam int HEIGHT_W    = 24;
  localparam int GRID_SIZE_W = 7;
  localparam int CELL_W      = 24;
  localparam int FRAC_W      = 16;

  // one in Q1.16, the sum of the three triangle weights
  localparam logic [FRAC_W:0] ONE_Q16 = (FRAC_W + 1)'(1) << FRAC_W;

  // register index, taken from paddr[3:2]
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ORIGIN_X  = 2'd0;
  localparam reg_idx_t REG_ORIGIN_Z  = 2'd1;
  localparam reg_idx_t REG_INV_CELL  = 2'd2;
  localparam reg_idx_t REG_GRID_SIZE = 2'd3;

  // request kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]       origin_x;
    logic [POS_W-1:0]       origin_z;
    logic [31:0]            inv_cell_size;
    logic [GRID_SIZE_W-1:0] grid_size;
  } cfg_t;

endpackage
`default_nettype wire

### hw/rtl/ths_ram.sv
`default_nettype none
// ============================================================================
// ths_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module ths_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ths_cfg.sv
`default_nettype none
// ============================================================================
// ths_cfg
// Configuration registers behind the APB-style port.
// ============================================================================
module ths_cfg
  import ths_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[3:2];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ORIGIN_X:  cfg_r.origin_x      <= pwdata;
        REG_ORIGIN_Z:  cfg_r.origin_z      <= pwdata;
        REG_INV_CELL:  cfg_r.inv_cell_size <= pwdata;
        REG_GRID_SIZE: cfg_r.grid_size     <= pwdata[GRID_SIZE_W-1:0];
        default:       cfg_r               <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_X:  prdata = cfg_r.origin_x;
      REG_ORIGIN_Z:  prdata = cfg_r.origin_z;
      REG_INV_CELL:  prdata = cfg_r.inv_cell_size;
      REG_GRID_SIZE: prdata = CFG_DATA_W'(cfg_r.grid_size);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/ths_interp.sv
`default_nettype none
// ============================================================================
// ths_interp
// Barycentric weighting of three cell corners, one register stage, rounding.
// ============================================================================
module ths_interp
  import ths_pkg::*;
#(
  parameter int HEIGHT_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [HEIGHT_BITS-1:0] h00,
  input  wire logic signed [HEIGHT_BITS-1:0] h10,
  input  wire logic signed [HEIGHT_BITS-1:0] h01,
  input  wire logic signed [HEIGHT_BITS-1:0] h11,
  input  wire logic        [FRAC_W-1:0]      fx,
  input  wire logic        [FRAC_W-1:0]      fz,
  output logic signed      [HEIGHT_BITS-1:0] height
);

  localparam int PW = HEIGHT_BITS + FRAC_W + 2;
  localparam int SW = PW + 2;

  logic [FRAC_W:0]                fsum;
  logic                           lower;
  logic [FRAC_W:0]                wa, wb, wc;
  logic signed [HEIGHT_BITS-1:0]  ha;
  logic signed [PW-1:0]           pa_nxt, pb_nxt, pc_nxt;
  logic signed [PW-1:0]           pa_r, pb_r, pc_r;
  logic signed [SW-1:0]           acc;

  // pick the triangle on the diagonal from (1,0) to (0,1)
  assign fsum  = {1'b0, fx} + {1'b0, fz};
  assign lower = (fsum <= ONE_Q16);

  always_comb begin
    if (lower) begin
      ha = h00;
      wa = ONE_Q16 - fsum;
      wb = {1'b0, fx};
      wc = {1'b0, fz};
    end else begin
      ha = h11;
      wa = fsum - ONE_Q16;
      wb = ONE_Q16 - {1'b0, fz};
      wc = ONE_Q16 - {1'b0, fx};
    end
  end

  assign pa_nxt = PW'(ha)  * PW'($signed({1'b0, wa}));
  assign pb_nxt = PW'(h10) * PW'($signed({1'b0, wb}));
  assign pc_nxt = PW'(h01) * PW'($signed({1'b0, wc}));

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      pc_r <= pc_nxt;
    end
  end

  // round to nearest, halves up
  assign acc    = SW'(pa_r) + SW'(pb_r) + SW'(pc_r) + (SW'(1) <<< (FRAC_W - 1));
  assign height = HEIGHT_BITS'(acc >>> FRAC_W);

endmodule
`default_nettype wire

### hw/rtl/terrain_height_sampler.sv
`default_nettype none
// ============================================================================
// terrain_height_sampler
// Heightfield sampler: grid of vertex heights, triangle-split bilinear lookup.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one request per cycle. A write
//   request (in_action = 0) stores in_sample_height at (in_write_row,
//   in_write_col) and gives no result. A query request (in_action = 1) gives
//   exactly one result on the output channel (out_valid/out_ready): the
//   interpolated height and in_range, or zero with in_range low when the
//   grid is empty or the point falls outside it.
//   The user must write configuration (origin, reciprocal cell size, grid
//   size) over the APB-style port only while no request is in flight; the
//   block does not enforce this. pready is tied high. A query passes stages
//   A to E and the output register. Throughput: one request per cycle when
//   not stalled. The four heights of a cell come from four RAM banks split
//   by row and column parity, so all four corners are read in the same cycle.
//   Writes go to the banks in request order at the same stage where queries
//   read, so a query always sees every earlier write.
//   Stalls: each stage advances when the one after it is empty or moving, so
//   a held result only stops the pipeline once all stages are full.
//   Reset clears the configuration and the pipeline valid bits; the height
//   store holds no defined value until each entry is written.
// ============================================================================
module terrain_height_sampler
  import ths_pkg::*;
#(
  parameter int GRID_MAX    = 64,
  parameter int HEIGHT_BITS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_action,
  input  wire logic        [COORD_W-1:0]  in_write_col,
  input  wire logic        [COORD_W-1:0]  in_write_row,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_height,
  input  wire logic signed [POS_W-1:0]    in_world_x,
  input  wire logic signed [POS_W-1:0]    in_world_z,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed      [HEIGHT_W-1:0] out_height,
  output logic                            out_in_range,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [CFG_ADDR_W-1:0]      paddr,
  input  wire logic [CFG_DATA_W-1:0]      pwdata,
  output logic      [CFG_DATA_W-1:0]      prdata,
  output logic                            pready
);

  // cell index width, bank geometry
  localparam int CW   = $clog2(GRID_MAX);
  localparam int HALF = (GRID_MAX + 1) / 2;
  localparam int HW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int BANK_DEPTH = HALF * HALF;
  localparam int BAW  = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  // widths for grid size and write coordinate compares
  localparam int GW   = $clog2(GRID_MAX + 1);
  localparam int LW   = (GW > GRID_SIZE_W) ? GW : GRID_SIZE_W;
  localparam int IW   = (GW > COORD_W) ? GW : COORD_W;

  function automatic logic [BAW-1:0] bank_addr(input logic [HW-1:0] rh,
                                               input logic [HW-1:0] ch);
    return BAW'(rh) * BAW'(HALF) + BAW'(ch);
  endfunction

  cfg_t cfg;

  ths_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // Last valid cell index plus one: grid size saturated to GRID_MAX, minus one.
  // Zero for an empty grid, so no cell ever compares below it.
  logic [LW-1:0] eff_size;
  logic [LW-1:0] lim;

  assign eff_size = (LW'(cfg.grid_size) > LW'(GRID_MAX)) ? LW'(GRID_MAX)
                                                         : LW'(cfg.grid_size);
  assign lim      = (eff_size < LW'(2)) ? '0 : eff_size - LW'(1);

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its occupant moves on.
  // A write request leaves the pipeline at the last stage without a result.
  // --------------------------------------------------------------------------
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, out_v_r;
  logic a_act_r, b_act_r, c_act_r, d_act_r, e_act_r;
  logic en_a, en_b, en_c, en_d, en_e, en_out;

  assign en_out   = !out_v_r || out_ready;
  assign en_e     = !e_v_r || (e_act_r == ACT_WRITE) || en_out;
  assign en_d     = !d_v_r || en_e;
  assign en_c     = !c_v_r || en_d;
  assign en_b     = !b_v_r || en_c;
  assign en_a     = !a_v_r || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      e_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en_a)   a_v_r   <= in_valid;
      if (en_b)   b_v_r   <= a_v_r;
      if (en_c)   c_v_r   <= b_v_r;
      if (en_d)   d_v_r   <= c_v_r;
      if (en_e)   e_v_r   <= d_v_r;
      if (en_out) out_v_r <= e_v_r && (e_act_r == ACT_QUERY);
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: offset from the terrain origin, write range check.
  // --------------------------------------------------------------------------
  logic [POS_W:0]        a_tx_nxt, a_tz_nxt;
  logic [POS_W:0]        a_tx_r, a_tz_r;
  logic                  a_wr_ok_nxt, a_wr_ok_r;
  logic [COORD_W-1:0]    a_col_r, a_row_r;
  logic [SAMPLE_W-1:0]   a_sample_r;

  assign a_tx_nxt = (POS_W + 1)'(in_world_x) - (POS_W + 1)'($signed(cfg.origin_x));
  assign a_tz_nxt = (POS_W + 1)'(in_world_z) - (POS_W + 1)'($signed(cfg.origin_z));
  assign a_wr_ok_nxt = (IW'(in_write_col) < IW'(GRID_MAX)) &&
                       (IW'(in_write_row) < IW'(GRID_MAX));

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_act_r    <= in_action;
      a_tx_r     <= a_tx_nxt;
      a_tz_r     <= a_tz_nxt;
      a_wr_ok_r  <= a_wr_ok_nxt;
      a_col_r    <= in_write_col;
      a_row_r    <= in_write_row;
      a_sample_r <= in_sample_height;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: scale by the reciprocal cell size; split cell and fraction.
  // A negative offset lies outside unless the reciprocal is zero, in which
  // case the product is zero and the point maps to cell (0,0).
  // --------------------------------------------------------------------------
  logic [2*POS_W-1:0]  prod_x, prod_z;
  logic                inv_nz;
  logic [CELL_W-1:0]   b_cx_r, b_cz_r;
  logic [FRAC_W-1:0]   b_fx_r, b_fz_r;
  logic                b_negx_r, b_negz_r;
  logic                b_wr_ok_r;
  logic [COORD_W-1:0]  b_col_r, b_row_r;
  logic [SAMPLE_W-1:0] b_sample_r;

  assign prod_x = (2 * POS_W)'(a_tx_r[POS_W-1:0]) * (2 * POS_W)'(cfg.inv_cell_size);
  assign prod_z = (2 * POS_W)'(a_tz_r[POS_W-1:0]) * (2 * POS_W)'(cfg.inv_cell_size);
  assign inv_nz = (cfg.inv_cell_size != '0);

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_act_r    <= a_act_r;
      b_cx_r     <= prod_x[2*POS_W-1 -: CELL_W];
      b_cz_r     <= prod_z[2*POS_W-1 -: CELL_W];
      b_fx_r     <= prod_x[2*POS_W-1-CELL_W -: FRAC_W];
      b_fz_r     <= prod_z[2*POS_W-1-CELL_W -: FRAC_W];
      b_negx_r   <= a_tx_r[POS_W] && inv_nz;
      b_negz_r   <= a_tz_r[POS_W] && inv_nz;
      b_wr_ok_r  <= a_wr_ok_r;
      b_col_r    <= a_col_r;
      b_row_r    <= a_row_r;
      b_sample_r <= a_sample_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: cell range check, then bank addresses for the RAM access.
  // --------------------------------------------------------------------------
  logic                c_in_range_nxt, c_in_range_r;
  logic [CW-1:0]       c_cx_r, c_cz_r;
  logic [FRAC_W-1:0]   c_fx_r, c_fz_r;
  logic                c_wr_ok_r;
  logic [COORD_W-1:0]  c_col_r, c_row_r;
  logic [SAMPLE_W-1:0] c_sample_r;

  assign c_in_range_nxt = !b_negx_r && !b_negz_r &&
                          (b_cx_r < CELL_W'(lim)) && (b_cz_r < CELL_W'(lim));

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_act_r      <= b_act_r;
      c_in_range_r <= c_in_range_nxt;
      c_cx_r       <= b_cx_r[CW-1:0];
      c_cz_r       <= b_cz_r[CW-1:0];
      c_fx_r       <= b_fx_r;
      c_fz_r       <= b_fz_r;
      c_wr_ok_r    <= b_wr_ok_r;
      c_col_r      <= b_col_r;
      c_row_r      <= b_row_r;
      c_sample_r   <= b_sample_r;
    end
  end

  // Even-parity bank holds cz or cz+1, whichever is even; odd bank likewise.
  logic [HW-1:0]          rh_even, rh_odd, ch_even, ch_odd;
  logic [HW-1:0]          wr_rh, wr_ch;
  logic [BAW-1:0]         raddr00, raddr01, raddr10, raddr11, waddr;
  logic                   wr_go;
  logic [1:0]             wr_bank;
  logic [HEIGHT_BITS-1:0] wdata;

  assign rh_odd  = HW'(c_cz_r >> 1);
  assign rh_even = HW'(c_cz_r >> 1) + HW'(c_cz_r[0]);
  assign ch_odd  = HW'(c_cx_r >> 1);
  assign ch_even = HW'(c_cx_r >> 1) + HW'(c_cx_r[0]);

  assign raddr00 = bank_addr(rh_even, ch_even);
  assign raddr01 = bank_addr(rh_even, ch_odd);
  assign raddr10 = bank_addr(rh_odd,  ch_even);
  assign raddr11 = bank_addr(rh_odd,  ch_odd);

  assign wr_rh   = HW'(c_row_r >> 1);
  assign wr_ch   = HW'(c_col_r >> 1);
  assign waddr   = bank_addr(wr_rh, wr_ch);
  assign wr_bank = {c_row_r[0], c_col_r[0]};
  assign wr_go   = en_d && c_v_r && (c_act_r == ACT_WRITE) && c_wr_ok_r;
  assign wdata   = HEIGHT_BITS'(c_sample_r);

  // --------------------------------------------------------------------------
  // Height banks, indexed by {row parity, column parity}. Read data belongs
  // to stage D and holds while D is stalled.
  // --------------------------------------------------------------------------
  logic [HEIGHT_BITS-1:0] rd00, rd01, rd10, rd11;

  ths_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(BANK_DEPTH)) u_bank00 (
    .clk(clk), .we(wr_go && (wr_bank == 2'b00)), .waddr(waddr), .wdata(wdata),
    .re(en_d), .raddr(raddr00), .rdata(rd00)
  );

  ths_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(BANK_DEPTH)) u_bank01 (
    .clk(clk), .we(wr_go && (wr_bank == 2'b01)), .waddr(waddr), .wdata(wdata),
    .re(en_d), .raddr(raddr01), .rdata(rd01)
  );

  ths_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(BANK_DEPTH)) u_bank10 (
    .clk(clk), .we(wr_go && (wr_bank == 2'b10)), .waddr(waddr), .wdata(wdata),
    .re(en_d), .raddr(raddr10), .rdata(rd10)
  );

  ths_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(BANK_DEPTH)) u_bank11 (
    .clk(clk), .we(wr_go && (wr_bank == 2'b11)), .waddr(waddr), .wdata(wdata),
    .re(en_d), .raddr(raddr11), .rdata(rd11)
  );

  // --------------------------------------------------------------------------
  // Stage D: map banks back to cell corners, weight the triangle.
  // --------------------------------------------------------------------------
  logic                   d_in_range_r;
  logic [FRAC_W-1:0]      d_fx_r, d_fz_r;
  logic                   d_px_r, d_pz_r;
  logic [HEIGHT_BITS-1:0] h00, h10, h01, h11;

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_act_r      <= c_act_r;
      d_in_range_r <= c_in_range_r;
      d_fx_r       <= c_fx_r;
      d_fz_r       <= c_fz_r;
      d_px_r       <= c_cx_r[0];
      d_pz_r       <= c_cz_r[0];
    end
  end

  always_comb begin
    unique case ({d_pz_r, d_px_r})
      2'b00: begin
        h00 = rd00; h10 = rd01; h01 = rd10; h11 = rd11;
      end
      2'b01: begin
        h00 = rd01; h10 = rd00; h01 = rd11; h11 = rd10;
      end
      2'b10: begin
        h00 = rd10; h10 = rd11; h01 = rd00; h11 = rd01;
      end
      default: begin
        h00 = rd11; h10 = rd10; h01 = rd01; h11 = rd00;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage E: weighted products registered inside the interpolator; sum and
  // round feed the output register.
  // --------------------------------------------------------------------------
  logic                          e_in_range_r;
  logic signed [HEIGHT_BITS-1:0] interp_height;

  ths_interp #(.HEIGHT_BITS(HEIGHT_BITS)) u_interp (
    .clk    (clk),
    .en     (en_e),
    .h00    (h00),
    .h10    (h10),
    .h01    (h01),
    .h11    (h11),
    .fx     (d_fx_r),
    .fz     (d_fz_r),
    .height (interp_height)
  );

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_act_r      <= d_act_r;
      e_in_range_r <= d_in_range_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold until taken; drop the height outside the grid.
  // --------------------------------------------------------------------------
  logic [HEIGHT_W-1:0] out_height_nxt, out_height_r;
  logic                out_in_range_r;

  assign out_height_nxt = e_in_range_r ?
                          HEIGHT_W'(interp_height[HEIGHT_BITS-1:0]) : '0;

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_height_r   <= out_height_nxt;
      out_in_range_r <= e_in_range_r;
    end
  end

  assign out_valid    = out_v_r;
  assign out_height   = out_height_r;
  assign out_in_range = out_in_range_r;

endmodule
`default_nettype wire
